### hw/rtl/sia_pkg.sv
// shared types, opcodes and status codes for the signed integer alu
package sia_pkg;
    localparam int WordWidth = 32;
    localparam int ShiftLimit = 32;
    localparam int DivStages = WordWidth / 4;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_REM = 4'd4, OP_MOD = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7,
        OP_XOR = 4'd8, OP_SHL = 4'd9, OP_SHR = 4'd10, OP_BIT = 4'd11,
        OP_ABS = 4'd12, OP_NEG = 4'd13, OP_NOT = 4'd14, OP_SIGN = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_OVERFLOW = 2'd2, ST_BADINDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [3:0]  action;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result;
        logic [1:0]  status;
    } t_out_item;

    // per-stage context carried alongside the datapath
    typedef struct packed {
        t_op              op;
        logic signed [WordWidth:0] simple;   // one extra bit for overflow check
        t_status          st;
        logic             a_neg;
        logic             b_neg;
        logic [WordWidth-1:0] b_mag;
        logic [WordWidth-1:0] b_raw;
    } t_ctx;
endpackage

### hw/rtl/sia_if.sv
// valid/ready channel interfaces for items in and out
interface sia_in_if;
    logic               valid;
    logic               ready;
    sia_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sia_out_if;
    logic               valid;
    logic               ready;
    sia_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sia_decode.sv
// first stage: operand sign extension and the operations that need neither divider nor multiplier
module sia_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  sia_pkg::t_in_item     i_item,
    output logic                  o_valid,
    output sia_pkg::t_ctx         o_ctx,
    output logic [sia_pkg::WordWidth-1:0] o_a_mag,
    output logic signed [sia_pkg::WordWidth-1:0] o_a,
    output logic signed [sia_pkg::WordWidth-1:0] o_b
);
    localparam int W = sia_pkg::WordWidth;
    localparam int SW = $clog2(sia_pkg::ShiftLimit + 1);

    logic signed [W-1:0] a, b;
    logic signed [W:0]   ax, bx, r;
    logic signed [W+1:0] amt;
    logic [SW-1:0]       sh;
    logic                right;
    sia_pkg::t_op        op;
    sia_pkg::t_status    st;
    sia_pkg::t_ctx       n_ctx;
    logic                r_valid;
    sia_pkg::t_ctx       r_ctx;
    logic [W-1:0]        r_a_mag;
    logic signed [W-1:0] r_a, r_b;

    always_comb begin
        a = i_item.operand_a[W-1:0];
        b = i_item.operand_b[W-1:0];
        ax = {a[W-1], a};
        bx = {b[W-1], b};
        op = sia_pkg::t_op'(i_item.action);
        amt = (op == sia_pkg::OP_SHR) ? -{bx[W], bx} : {bx[W], bx};
        right = amt[W+1];
        if (right) begin
            sh = ((-amt) > (W+2)'(sia_pkg::ShiftLimit)) ? SW'(sia_pkg::ShiftLimit)
                                                        : SW'(-amt);
        end else begin
            sh = (amt > (W+2)'(sia_pkg::ShiftLimit)) ? SW'(sia_pkg::ShiftLimit)
                                                     : SW'(amt);
        end
        st = sia_pkg::ST_OK;
        r = '0;
        case (op)
            sia_pkg::OP_ADD: r = ax + bx;
            sia_pkg::OP_SUB: r = ax - bx;
            sia_pkg::OP_AND: r = ax & bx;
            sia_pkg::OP_OR:  r = ax | bx;
            sia_pkg::OP_XOR: r = ax ^ bx;
            sia_pkg::OP_SHL, sia_pkg::OP_SHR: begin
                // left shift keeps one extra bit, any lost bit means overflow
                if (right) begin
                    r = ax >>> sh;
                end else if (sh >= SW'(W)) begin
                    r = (a == '0) ? '0 : {1'b0, 1'b1, {(W-1){1'b0}}};
                end else begin
                    r = ((ax <<< sh) >>> sh) == ax ? (ax <<< sh)
                        : {1'b0, 1'b1, {(W-1){1'b0}}};
                end
            end
            sia_pkg::OP_BIT: begin
                if (b[W-1]) begin
                    st = sia_pkg::ST_BADINDEX;
                end else if (b >= (W)'(W-1)) begin
                    r = {{W{1'b0}}, a[W-1]};
                end else begin
                    r = {{W{1'b0}}, a[b[$clog2(W)-1:0]]};
                end
            end
            sia_pkg::OP_ABS:  r = a[W-1] ? -ax : ax;
            sia_pkg::OP_NEG:  r = -ax;
            sia_pkg::OP_NOT:  r = ~ax;
            sia_pkg::OP_SIGN: r = (a == '0) ? '0 : (a[W-1] ? '1 : (W+1)'(1));
            sia_pkg::OP_DIV, sia_pkg::OP_REM, sia_pkg::OP_MOD:
                if (b == '0) st = sia_pkg::ST_DIVZERO;
            default: r = '0;
        endcase
        n_ctx.op = op;
        n_ctx.simple = r;
        n_ctx.st = st;
        n_ctx.a_neg = a[W-1];
        n_ctx.b_neg = b[W-1];
        n_ctx.b_mag = b[W-1] ? W'(-b) : W'(b);
        n_ctx.b_raw = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctx <= n_ctx;
            r_a_mag <= a[W-1] ? W'(-a) : W'(a);
            r_a <= a;
            r_b <= b;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx = r_ctx;
    assign o_a_mag = r_a_mag;
    assign o_a = r_a;
    assign o_b = r_b;
endmodule

### hw/rtl/sia_divmul.sv
// pipelined radix-2 divider, four quotient bits per stage, with the product carried alongside
module sia_divmul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  sia_pkg::t_ctx         i_ctx,
    input  logic [sia_pkg::WordWidth-1:0] i_a_mag,
    input  logic signed [sia_pkg::WordWidth-1:0] i_a,
    input  logic signed [sia_pkg::WordWidth-1:0] i_b,
    output logic                  o_valid,
    output sia_pkg::t_ctx         o_ctx,
    output logic [sia_pkg::WordWidth-1:0] o_quo,
    output logic [sia_pkg::WordWidth-1:0] o_rem,
    output logic signed [2*sia_pkg::WordWidth-1:0] o_prod
);
    localparam int W = sia_pkg::WordWidth;
    localparam int N = sia_pkg::DivStages;
    localparam int BPS = W / N;

    logic                r_valid [N];
    sia_pkg::t_ctx       r_ctx [N];
    logic [W-1:0]        r_num [N];
    logic [W-1:0]        r_rem [N];
    logic signed [2*W-1:0] r_prod [N];
    logic [W-1:0]        n_num [N];
    logic [W-1:0]        n_rem [N];

    // each stage shifts BPS numerator bits into the partial remainder
    always_comb begin
        logic [W:0]   t;
        logic [W-1:0] num, rm, d;
        for (int s = 0; s < N; s++) begin
            num = (s == 0) ? i_a_mag : r_num[s-1];
            rm  = (s == 0) ? '0 : r_rem[s-1];
            d   = (s == 0) ? i_ctx.b_mag : r_ctx[s-1].b_mag;
            for (int k = 0; k < BPS; k++) begin
                t = {rm, num[W-1]};
                num = {num[W-2:0], 1'b0};
                if (t >= {1'b0, d}) begin
                    t = t - {1'b0, d};
                    num[0] = 1'b1;
                end
                rm = t[W-1:0];
            end
            n_num[s] = num;
            n_rem[s] = rm;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < N; s++) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= (s == 0) ? i_valid : r_valid[s-1];
            end
            if (i_en) begin
                r_ctx[s] <= (s == 0) ? i_ctx : r_ctx[s-1];
                r_num[s] <= n_num[s];
                r_rem[s] <= n_rem[s];
                // product registered at the first stage, then carried
                r_prod[s] <= (s == 0) ? (2*W)'(i_a * i_b) : r_prod[s-1];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_ctx = r_ctx[N-1];
    assign o_quo = r_num[N-1];
    assign o_rem = r_rem[N-1];
    assign o_prod = r_prod[N-1];
endmodule

### hw/rtl/sia_finish.sv
// last stage: sign fix of quotient and remainder, result select, range check
module sia_finish (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  sia_pkg::t_ctx         i_ctx,
    input  logic [sia_pkg::WordWidth-1:0] i_quo,
    input  logic [sia_pkg::WordWidth-1:0] i_rem,
    input  logic signed [2*sia_pkg::WordWidth-1:0] i_prod,
    output logic                  o_valid,
    output sia_pkg::t_out_item    o_item
);
    localparam int W = sia_pkg::WordWidth;

    logic signed [2*W-1:0] wide;
    logic signed [W:0]     q, rm, rmod;
    sia_pkg::t_status      st;
    sia_pkg::t_out_item    n_item;
    logic                  r_valid;
    sia_pkg::t_out_item    r_item;

    always_comb begin
        q  = (i_ctx.a_neg ^ i_ctx.b_neg) ? -{1'b0, i_quo} : {1'b0, i_quo};
        rm = i_ctx.a_neg ? -{1'b0, i_rem} : {1'b0, i_rem};
        // floor mod: nonzero remainder with sign unlike divisor gets divisor added
        rmod = (rm != '0 && (rm[W] != i_ctx.b_neg))
             ? rm + {i_ctx.b_raw[W-1], i_ctx.b_raw} : rm;
        case (i_ctx.op)
            sia_pkg::OP_MUL: wide = i_prod;
            sia_pkg::OP_DIV: wide = (2*W)'(q);
            sia_pkg::OP_REM: wide = (2*W)'(rm);
            sia_pkg::OP_MOD: wide = (2*W)'(rmod);
            default:         wide = (2*W)'(i_ctx.simple);
        endcase
        st = i_ctx.st;
        if (st == sia_pkg::ST_OK && wide != (2*W)'(signed'(wide[W-1:0]))) begin
            st = sia_pkg::ST_OVERFLOW;
        end
        n_item.status = st;
        n_item.result = (st == sia_pkg::ST_OK) ? 32'(signed'(wide[W-1:0])) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;
endmodule

### hw/rtl/signed_integer_alu_top.sv
// stages from input accept to result valid: decode, 8 divider stages, finish
// throughput: one item per cycle; the whole pipeline advances together when the
// output register is empty or being taken
// the divider retires four quotient bits per stage
// reset clears all valid bits; payload registers are not reset
module signed_integer_alu_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sia_in_if.sink     i_in,
    sia_out_if.source  o_out
);
    localparam int W = sia_pkg::WordWidth;

    logic                  en;
    logic                  d_valid, m_valid;
    sia_pkg::t_ctx         d_ctx, m_ctx;
    logic [W-1:0]          d_a_mag, m_quo, m_rem;
    logic signed [W-1:0]   d_a, d_b;
    logic signed [2*W-1:0] m_prod;

    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    sia_decode u_decode (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_in.valid), .i_item(i_in.data),
        .o_valid(d_valid), .o_ctx(d_ctx), .o_a_mag(d_a_mag), .o_a(d_a), .o_b(d_b)
    );

    sia_divmul u_divmul (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_valid), .i_ctx(d_ctx),
        .i_a_mag(d_a_mag), .i_a(d_a), .i_b(d_b),
        .o_valid(m_valid), .o_ctx(m_ctx), .o_quo(m_quo), .o_rem(m_rem), .o_prod(m_prod)
    );

    sia_finish u_finish (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(m_valid), .i_ctx(m_ctx),
        .i_quo(m_quo), .i_rem(m_rem), .i_prod(m_prod),
        .o_valid(o_out.valid), .o_item(o_out.data)
    );

    a_nonzero_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status != sia_pkg::ST_OK |-> o_out.data.result == '0)
        else $error("error status with nonzero result");

    a_stall_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while pipeline stalled");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(m_valid) && $stable(d_valid))
        else $error("pipeline moved during stall");
endmodule

### tb/sv/alu_checker.sv
// scoreboard for the signed integer alu: predicts each result and compares it
module alu_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sia_in_if.sink       i_in,
    sia_out_if.sink      i_out,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    sia_pkg::t_out_item expected_results[$];

    // shift by a signed amount, magnitude clamped to the shift limit
    function automatic longint shift_by(longint v, longint s);
        longint m;
        if (s == 0) return v;
        m = (s < 0) ? -s : s;
        if (m > sia_pkg::ShiftLimit) m = sia_pkg::ShiftLimit;
        if (s > 0) return v <<< m;
        return v >>> m;
    endfunction

    function automatic sia_pkg::t_out_item alu_result(sia_pkg::t_in_item it);
        longint a, b, r, q;
        sia_pkg::t_status st;
        sia_pkg::t_out_item o;
        a = longint'($signed(it.operand_a));
        b = longint'($signed(it.operand_b));
        r = 0;
        st = sia_pkg::ST_OK;
        case (sia_pkg::t_op'(it.action))
            sia_pkg::OP_ADD: r = a + b;
            sia_pkg::OP_SUB: r = a - b;
            sia_pkg::OP_MUL: r = a * b;
            sia_pkg::OP_DIV, sia_pkg::OP_REM, sia_pkg::OP_MOD: begin
                if (b == 0) begin
                    st = sia_pkg::ST_DIVZERO;
                end else begin
                    q = a / b;
                    r = a - q * b;
                    if (sia_pkg::t_op'(it.action) == sia_pkg::OP_DIV) r = q;
                    else if (sia_pkg::t_op'(it.action) == sia_pkg::OP_MOD) r = (r + b) % b;
                end
            end
            sia_pkg::OP_AND: r = a & b;
            sia_pkg::OP_OR: r = a | b;
            sia_pkg::OP_XOR: r = a ^ b;
            sia_pkg::OP_SHL: r = shift_by(a, b);
            sia_pkg::OP_SHR: r = shift_by(a, -b);
            sia_pkg::OP_BIT: begin
                if (b < 0) st = sia_pkg::ST_BADINDEX;
                else r = (a >> ((b > sia_pkg::WordWidth - 1) ? sia_pkg::WordWidth - 1 : b)) & 1;
            end
            sia_pkg::OP_ABS: r = (a >= 0) ? a : -a;
            sia_pkg::OP_NEG: r = -a;
            sia_pkg::OP_NOT: r = -a - 1;
            default: r = (a == 0) ? 0 : ((a > 0) ? 1 : -1);
        endcase
        if (st == sia_pkg::ST_OK && (r > 64'sd2147483647 || r < -64'sd2147483648))
            st = sia_pkg::ST_OVERFLOW;
        if (st != sia_pkg::ST_OK) r = 0;
        o.result = r[31:0];
        o.status = st;
        return o;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        sia_pkg::t_out_item e;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) expected_results.push_back(alu_result(i_in.data));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    e = expected_results.pop_front();
                    if (i_out.data.result !== e.result)
                        report_mismatch($sformatf("result %h expected %h",
                            i_out.data.result, e.result));
                    if (i_out.data.status !== e.status)
                        report_mismatch($sformatf("status %0d expected %0d",
                            i_out.data.status, e.status));
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule

### tb/sv/testbench.sv
// top of the signed integer alu testbench: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int fail_count, pending;
    int send_idle_pct = 0, stall_pct = 0;
    bit holding_off = 0;
    int idle_cycles = 0;

    sia_in_if  in_ch();
    sia_out_if out_ch();

    signed_integer_alu_top dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));
    alu_checker u_checker (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // receiver side
    always @(posedge i_clk)
        out_ch.ready <= !holding_off && ($urandom_range(99, 0) >= stall_pct);

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000 | $urandom_range(3, 0);
            1: return 32'h7fff_fffc | $urandom_range(3, 0);
            2: return $urandom_range(40, 0);
            3: return -$urandom_range(40, 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(sia_pkg::t_op op, logic [31:0] a, logic [31:0] b);
        sia_pkg::t_in_item it;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        it.action = op;
        it.operand_a = a;
        it.operand_b = b;
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic random_items(int n);
        repeat (n) send_item(sia_pkg::t_op'($urandom_range(15, 0)), rand_operand(),
            rand_operand());
    endtask

    initial begin
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'd1, 32'd31};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: every operation on the extremes, plus the special cases
        for (int op = 0; op < 16; op++)
            send_item(sia_pkg::t_op'(op), edge_vals[op % 6], edge_vals[(op + 3) % 6]);
        send_item(sia_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_item(sia_pkg::OP_MOD, 32'hffff_fff9, 32'd3);
        send_item(sia_pkg::OP_REM, 32'd5, 32'd0);
        send_item(sia_pkg::OP_SHL, 32'h1234_5678, 32'hffff_ff00);
        send_item(sia_pkg::OP_SHR, 32'h8000_0000, 32'h8000_0000);
        send_item(sia_pkg::OP_BIT, 32'h8000_0000, 32'd100);
        send_item(sia_pkg::OP_BIT, 32'h5, 32'hffff_fffe);
        send_item(sia_pkg::OP_MUL, 32'h0001_0000, 32'h0000_8000);
        random_items(450);
        send_idle_pct = 83;
        random_items(450);
        send_idle_pct = 0;
        stall_pct = 83;
        random_items(450);
        send_idle_pct = 37;
        stall_pct = 37;
        random_items(350);
        // long receiver hold-off while items keep coming
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                holding_off = 1;
                repeat (60) @(posedge i_clk);
                holding_off = 0;
            end
            random_items(180);
        join
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
